// ===== sv/tlbpt_pkg.sv =====
// Package for the TLB and page-table translator.
// Holds default sizes, fixed field widths, controller state and command/status types.
// No dependencies.
package tlbpt_pkg;

    localparam int DEF_TLB_ENTRIES  = 16;
    localparam int DEF_PAGE_COUNT   = 256;
    localparam int DEF_OFFSET_WIDTH = 8;

    localparam int ADDR_W  = 16;
    localparam int FRAME_W = 8;
    localparam int TAG_W   = 8;
    localparam int COUNT_W = 32;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUOT,
        ST_REM,
        ST_LOOKUP,
        ST_RESOLVE
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic quot;
        logic rem;
        logic lookup;
        logic resolve;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } status_t;

endpackage

// ===== sv/tlb_page_table_translator.sv =====
// Top level of the TLB and page-table translator with demand paging.
// Joins tlbpt_ctrl and tlbpt_datapath. Uses tlbpt_pkg.
//
// A virtual address word is taken when start is high and busy is low. Its result
// appears on the result ports for exactly one cycle with done high, and must be
// taken then: the receiver cannot stall. The page number is reduced modulo
// PAGE_COUNT by a reciprocal multiply, then a multiply-subtract with one correction,
// followed by a TLB compare and page-table read step and an update step; done is
// registered from the update step. busy drops in the done cycle, so a new word can be
// taken then. After reset, busy stays high while the page-table valid memory is
// cleared one entry a cycle.
module tlb_page_table_translator
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES  = DEF_TLB_ENTRIES,
    parameter int PAGE_COUNT   = DEF_PAGE_COUNT,
    parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [ADDR_W-1:0]  virtual_address,
    output logic               done,
    output logic [ADDR_W-1:0]  phys_addr,
    output logic               tlb_hit,
    output logic               fault_flag,
    output logic [COUNT_W-1:0] translated_count,
    output logic [COUNT_W-1:0] hit_count,
    output logic [COUNT_W-1:0] fault_count
);

    cmd_t    cmd;
    status_t status;

    tlbpt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    tlbpt_datapath #(
        .TLB_ENTRIES  (TLB_ENTRIES),
        .PAGE_COUNT   (PAGE_COUNT),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .virtual_address  (virtual_address),
        .done             (done),
        .phys_addr        (phys_addr),
        .tlb_hit          (tlb_hit),
        .fault_flag       (fault_flag),
        .translated_count (translated_count),
        .hit_count        (hit_count),
        .fault_count      (fault_count)
    );

endmodule

// ===== sv/tlbpt_ctrl.sv =====
// Controller for the TLB and page-table translator.
// Sequences page-table clearing, page reduction, lookup and resolve. Uses tlbpt_pkg.
module tlbpt_ctrl
    import tlbpt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:   if (status.clear_last) state_next = ST_IDLE;
            ST_IDLE:    if (start) state_next = ST_QUOT;
            ST_QUOT:    state_next = ST_REM;
            ST_REM:     state_next = ST_LOOKUP;
            ST_LOOKUP:  state_next = ST_RESOLVE;
            ST_RESOLVE: state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd     = '0;
        busy    = 1'b1;
        unique case (state_reg)
            ST_CLEAR:   cmd.clear = 1'b1;
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_QUOT:    cmd.quot = 1'b1;
            ST_REM:     cmd.rem = 1'b1;
            ST_LOOKUP:  cmd.lookup = 1'b1;
            ST_RESOLVE: cmd.resolve = 1'b1;
            default:    busy = 1'b1;
        endcase
    end

endmodule

// ===== sv/tlbpt_datapath.sv =====
// Datapath for the TLB and page-table translator.
// Holds the TLB, page-table memories, page reduction by reciprocal multiply and counters.
// Uses tlbpt_pkg.
module tlbpt_datapath
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES  = DEF_TLB_ENTRIES,
    parameter int PAGE_COUNT   = DEF_PAGE_COUNT,
    parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [ADDR_W-1:0]  virtual_address,
    output logic               done,
    output logic [ADDR_W-1:0]  phys_addr,
    output logic               tlb_hit,
    output logic               fault_flag,
    output logic [COUNT_W-1:0] translated_count,
    output logic [COUNT_W-1:0] hit_count,
    output logic [COUNT_W-1:0] fault_count
);

    localparam int PAGE_W    = $clog2(PAGE_COUNT);
    localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
    localparam int VPN_W     = ADDR_W - OFFSET_WIDTH;
    // a page field of zero width is carried as one zero bit
    localparam int VPN_BITS  = (VPN_W > 0) ? VPN_W : 1;
    localparam int RECIP     = (1 << VPN_BITS) / PAGE_COUNT;
    localparam logic [31:0] RECIP_C = 32'(RECIP);
    localparam logic [31:0] PAGE_C  = 32'(PAGE_COUNT);

    // page-table memories
    logic                page_valid_mem [PAGE_COUNT];
    logic [FRAME_W-1:0]  page_frame_mem [PAGE_COUNT];
    logic                pv_rd_reg;
    logic [FRAME_W-1:0]  pf_rd_reg;

    // TLB
    logic [TAG_W-1:0]    tlb_page_reg  [TLB_ENTRIES];
    logic [FRAME_W-1:0]  tlb_frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] tlb_valid_reg, tlb_valid_next;
    logic [TLB_IDX_W-1:0]   fifo_ptr_reg, fifo_ptr_next;

    // working word
    logic [VPN_BITS-1:0]     vpn_reg;
    logic [OFFSET_WIDTH-1:0] offset_reg;
    logic [VPN_BITS-1:0]     quot_reg, quot_next;
    logic [31:0]             quot_prod;
    logic [31:0]             rem_raw;
    logic [31:0]             rem_fix;
    logic [PAGE_W-1:0]       rem_reg, rem_next;
    logic [TAG_W-1:0]        page_tag;
    logic                    hit_reg;
    logic [FRAME_W-1:0]      hit_frame_reg;
    logic                    match_any;
    logic [FRAME_W-1:0]      match_frame;

    // control and result state
    logic [PAGE_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [FRAME_W-1:0]  next_free_reg, next_free_next;
    logic [COUNT_W-1:0]  trans_cnt_reg, trans_cnt_next;
    logic [COUNT_W-1:0]  hit_cnt_reg, hit_cnt_next;
    logic [COUNT_W-1:0]  fault_cnt_reg, fault_cnt_next;
    logic                done_reg;
    logic [ADDR_W-1:0]   phys_reg;
    logic                hit_out_reg;
    logic                fault_out_reg;

    logic                fault;
    logic                miss_fill;
    logic [FRAME_W-1:0]  frame_sel;
    logic [31:0]         phys_wide;

    assign status.clear_last = (clr_cnt_reg == PAGE_W'(PAGE_COUNT - 1));

    // the quotient estimate is low by at most one, so one subtract finishes the remainder
    assign quot_prod = 32'(vpn_reg) * RECIP_C;
    assign rem_raw   = 32'(vpn_reg) - 32'(quot_reg) * PAGE_C;
    assign rem_fix   = (rem_raw >= PAGE_C) ? rem_raw - PAGE_C : rem_raw;
    assign page_tag  = TAG_W'(rem_reg);

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (cmd.quot)
            quot_next = VPN_BITS'(quot_prod >> VPN_BITS);
        if (cmd.rem)
            rem_next = PAGE_W'(rem_fix);
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (cmd.load)
        begin
            vpn_reg    <= VPN_BITS'(virtual_address >> OFFSET_WIDTH);
            offset_reg <= virtual_address[OFFSET_WIDTH-1:0];
        end
    end

    // a page sits in at most one TLB slot, so the matches can be OR-ed together
    always_comb
    begin
        match_any   = 1'b0;
        match_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            if (tlb_valid_reg[i] && (tlb_page_reg[i] == page_tag))
            begin
                match_any   = 1'b1;
                match_frame = match_frame | tlb_frame_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_reg       <= match_any;
            hit_frame_reg <= match_frame;
        end
    end

    assign fault     = !hit_reg && !pv_rd_reg;
    assign miss_fill = cmd.resolve && !hit_reg;

    always_comb
    begin
        priority if (hit_reg)
            frame_sel = hit_frame_reg;
        else if (pv_rd_reg)
            frame_sel = pf_rd_reg;
        else
            frame_sel = next_free_reg;
    end

    assign phys_wide = 32'({frame_sel, offset_reg});

    // page-table memories: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
            page_valid_mem[clr_cnt_reg] <= 1'b0;
        else if (cmd.resolve && fault)
            page_valid_mem[rem_reg] <= 1'b1;
        if (cmd.lookup)
            pv_rd_reg <= page_valid_mem[rem_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resolve && fault)
            page_frame_mem[rem_reg] <= next_free_reg;
        if (cmd.lookup)
            pf_rd_reg <= page_frame_mem[rem_reg];
    end

    always_ff @(posedge clk)
    begin
        if (miss_fill)
        begin
            tlb_page_reg[fifo_ptr_reg]  <= page_tag;
            tlb_frame_reg[fifo_ptr_reg] <= frame_sel;
        end
    end

    always_comb
    begin
        tlb_valid_next = tlb_valid_reg;
        fifo_ptr_next  = fifo_ptr_reg;
        if (miss_fill)
        begin
            tlb_valid_next[fifo_ptr_reg] = 1'b1;
            fifo_ptr_next = (fifo_ptr_reg == TLB_IDX_W'(TLB_ENTRIES - 1))
                            ? '0 : fifo_ptr_reg + TLB_IDX_W'(1);
        end
    end

    always_comb
    begin
        clr_cnt_next   = cmd.clear ? clr_cnt_reg + PAGE_W'(1) : clr_cnt_reg;
        next_free_next = (cmd.resolve && fault) ? next_free_reg + FRAME_W'(1)
                                                : next_free_reg;
        trans_cnt_next = trans_cnt_reg;
        hit_cnt_next   = hit_cnt_reg;
        fault_cnt_next = fault_cnt_reg;
        if (cmd.resolve)
        begin
            // hold each counter once it reaches all ones
            if (trans_cnt_reg != '1)
                trans_cnt_next = trans_cnt_reg + COUNT_W'(1);
            if (hit_reg && (hit_cnt_reg != '1))
                hit_cnt_next = hit_cnt_reg + COUNT_W'(1);
            if (fault && (fault_cnt_reg != '1))
                fault_cnt_next = fault_cnt_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            tlb_valid_reg <= '0;
            fifo_ptr_reg  <= '0;
            next_free_reg <= '0;
            trans_cnt_reg <= '0;
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            tlb_valid_reg <= tlb_valid_next;
            fifo_ptr_reg  <= fifo_ptr_next;
            next_free_reg <= next_free_next;
            trans_cnt_reg <= trans_cnt_next;
            hit_cnt_reg   <= hit_cnt_next;
            fault_cnt_reg <= fault_cnt_next;
            done_reg      <= cmd.resolve;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resolve)
        begin
            phys_reg      <= phys_wide[ADDR_W-1:0];
            hit_out_reg   <= hit_reg;
            fault_out_reg <= fault;
        end
    end

    assign done             = done_reg;
    assign phys_addr        = phys_reg;
    assign tlb_hit          = hit_out_reg;
    assign fault_flag       = fault_out_reg;
    assign translated_count = trans_cnt_reg;
    assign hit_count        = hit_cnt_reg;
    assign fault_count      = fault_cnt_reg;

endmodule

// ===== tb/tlbpt_xlat_checker.sv =====
// Translation checker for tlb_page_table_translator: watches the start/busy and done
// channels, tracks TLB, page table and counters, and compares each result word.
// Uses tlbpt_pkg.
module tlbpt_xlat_checker
    import tlbpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [ADDR_W-1:0]  virtual_address,
    input  logic               done,
    input  logic [ADDR_W-1:0]  phys_addr,
    input  logic               tlb_hit,
    input  logic               fault_flag,
    input  logic [COUNT_W-1:0] translated_count,
    input  logic [COUNT_W-1:0] hit_count,
    input  logic [COUNT_W-1:0] fault_count,
    output int                 mismatches,
    output int                 outstanding
);

    localparam int PAGE_W = $clog2(DEF_PAGE_COUNT);
    localparam int SLOT_W = $clog2(DEF_TLB_ENTRIES);

    typedef struct packed {
        logic [ADDR_W-1:0]  phys;
        logic               hit;
        logic               fault;
        logic [COUNT_W-1:0] xlat_n;
        logic [COUNT_W-1:0] hit_n;
        logic [COUNT_W-1:0] fault_n;
    } xlat_t;

    logic [TAG_W-1:0]   tlb_tag   [DEF_TLB_ENTRIES];
    logic [FRAME_W-1:0] tlb_frame [DEF_TLB_ENTRIES];
    logic               tlb_live  [DEF_TLB_ENTRIES];
    logic [FRAME_W-1:0] frame_of  [DEF_PAGE_COUNT];
    logic               mapped    [DEF_PAGE_COUNT];
    logic [SLOT_W-1:0]  victim;
    logic [FRAME_W-1:0] free_frame;
    logic [COUNT_W-1:0] n_xlat;
    logic [COUNT_W-1:0] n_hit;
    logic [COUNT_W-1:0] n_fault;
    xlat_t              xlat_q[$];
    int                 errs;

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [COUNT_W-1:0] want,
                                        input logic [COUNT_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errs++;
        end
    endfunction

    task automatic translate_word(input logic [ADDR_W-1:0] va);
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic               hit;
        logic               fault;
        xlat_t              r;
        int                 i;
        page  = PAGE_W'((va >> DEF_OFFSET_WIDTH) % DEF_PAGE_COUNT);
        frame = '0;
        hit   = 1'b0;
        fault = 1'b0;
        // scan downward so the lowest matching slot wins
        for (i = DEF_TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (tlb_live[i] && tlb_tag[i] == TAG_W'(page))
            begin
                hit   = 1'b1;
                frame = tlb_frame[i];
            end
        end
        if (!hit)
        begin
            if (mapped[page])
                frame = frame_of[page];
            else
            begin
                fault          = 1'b1;
                frame          = free_frame;
                frame_of[page] = frame;
                mapped[page]   = 1'b1;
                free_frame     = free_frame + 1'b1;
            end
            tlb_tag[victim]   = TAG_W'(page);
            tlb_frame[victim] = frame;
            tlb_live[victim]  = 1'b1;
            victim = (victim == SLOT_W'(DEF_TLB_ENTRIES - 1)) ? '0 : victim + 1'b1;
        end
        n_xlat = bump(n_xlat);
        if (hit)
            n_hit = bump(n_hit);
        if (fault)
            n_fault = bump(n_fault);
        r.phys    = ADDR_W'((32'(frame) << DEF_OFFSET_WIDTH)
                            | (32'(va) & ((32'd1 << DEF_OFFSET_WIDTH) - 1)));
        r.hit     = hit;
        r.fault   = fault;
        r.xlat_n  = n_xlat;
        r.hit_n   = n_hit;
        r.fault_n = n_fault;
        xlat_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEF_TLB_ENTRIES; i++)
            begin
                tlb_tag[i]   = '0;
                tlb_frame[i] = '0;
                tlb_live[i]  = 1'b0;
            end
            for (int p = 0; p < DEF_PAGE_COUNT; p++)
            begin
                frame_of[p] = '0;
                mapped[p]   = 1'b0;
            end
            victim      = '0;
            free_frame  = '0;
            n_xlat      = '0;
            n_hit       = '0;
            n_fault     = '0;
            errs        = 0;
            xlat_q.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            // compare before predicting: a word taken in the done cycle answers later
            if (done)
            begin
                if (xlat_q.size() == 0)
                begin
                    $error("result word with no translation pending");
                    errs++;
                end
                else
                begin
                    xlat_t w;
                    w = xlat_q.pop_front();
                    check_field("phys_addr", COUNT_W'(w.phys), COUNT_W'(phys_addr));
                    check_field("tlb_hit", COUNT_W'(w.hit), COUNT_W'(tlb_hit));
                    check_field("fault_flag", COUNT_W'(w.fault), COUNT_W'(fault_flag));
                    check_field("translated_count", w.xlat_n, translated_count);
                    check_field("hit_count", w.hit_n, hit_count);
                    check_field("fault_count", w.fault_n, fault_count);
                end
            end
            if (start && !busy)
                translate_word(virtual_address);
            outstanding <= xlat_q.size();
            mismatches  <= errs;
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for tlb_page_table_translator: drives virtual address words,
// runs the watchdog and prints the verdict. Uses tlbpt_pkg and tlbpt_xlat_checker.
module tb;
    import tlbpt_pkg::*;

    localparam int RANDOM_WORDS   = 1700;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 30;
    localparam int HOT_PAGES      = 12;
    localparam int PAGE_BITS      = ADDR_W - DEF_OFFSET_WIDTH;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [ADDR_W-1:0]  virtual_address = '0;
    logic               busy;
    logic               done;
    logic [ADDR_W-1:0]  phys_addr;
    logic               tlb_hit;
    logic               fault_flag;
    logic [COUNT_W-1:0] translated_count;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] fault_count;
    int                 mismatches;
    int                 outstanding;
    int                 quiet_cycles = 0;
    int                 stretch_left = 0;

    always #5 clk = ~clk;

    tlb_page_table_translator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .virtual_address  (virtual_address),
        .done             (done),
        .phys_addr        (phys_addr),
        .tlb_hit          (tlb_hit),
        .fault_flag       (fault_flag),
        .translated_count (translated_count),
        .hit_count        (hit_count),
        .fault_count      (fault_count)
    );

    tlbpt_xlat_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .virtual_address  (virtual_address),
        .done             (done),
        .phys_addr        (phys_addr),
        .tlb_hit          (tlb_hit),
        .fault_flag       (fault_flag),
        .translated_count (translated_count),
        .hit_count        (hit_count),
        .fault_count      (fault_count),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || done === 1'b1)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Idle a random gap (or none inside a back-to-back stretch), then hold start
    // until the word is taken.
    task automatic send_word(input logic [ADDR_W-1:0] va);
        int gap;
        if (stretch_left > 0)
        begin
            gap = 0;
            stretch_left--;
        end
        else
        begin
            gap = $urandom_range(0, 16);
            if ($urandom_range(0, 19) == 0)
                stretch_left = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start           <= 1'b1;
        virtual_address <= va;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [PAGE_BITS-1:0] hot[HOT_PAGES];
        logic [PAGE_BITS-1:0] page;
        logic [PAGE_BITS-1:0] sweep;
        int                   hot_at;
        int                   pick;

        sweep  = '0;
        hot_at = 0;
        for (int i = 0; i < HOT_PAGES; i++)
            hot[i] = PAGE_BITS'($urandom);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // page 0 first: an empty TLB must not hit it
        send_word(16'h0000);
        send_word(16'h00FF);
        send_word(16'hFF00);
        send_word(16'hFFFF);
        send_word(16'h01AA);
        // fill the remaining slots and wrap the ring so page 0 drops out
        for (int p = 2; p < 16; p++)
            send_word({PAGE_BITS'(p), 8'($urandom)});
        // page table hit after eviction, then a TLB hit on page 15 in the wrapped slot 0
        send_word(16'h0055);
        send_word(16'h0F33);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                page = hot[$urandom_range(0, HOT_PAGES - 1)];
            else if (pick < 75)
            begin
                // walk every page so the free frame count wraps
                page  = sweep;
                sweep = sweep + 1'b1;
            end
            else if (pick < 90)
                page = PAGE_BITS'(8'hA0 + $urandom_range(0, 31));
            else
                page = PAGE_BITS'($urandom);
            send_word({page, 8'($urandom)});
            hot[hot_at] = page;
            hot_at      = (hot_at + 1) % HOT_PAGES;
        end
        start <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== tlb_page_table_translator.f =====
sv/tlbpt_pkg.sv
sv/tlbpt_ctrl.sv
sv/tlbpt_datapath.sv
sv/tlb_page_table_translator.sv
tb/tlbpt_xlat_checker.sv
tb/tb.sv
